// ----- hw/rtl/ffha_pkg.sv -----
package ffha_pkg;

    localparam int unsigned HEAP_BYTES   = 33554432;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned MAX_SEGMENTS = 64;

    localparam int unsigned IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int unsigned CNT_W   = IDX_W + 1;
    localparam int unsigned START_W = 25;
    localparam int unsigned BYTES_W = 26;
    localparam int unsigned ENTRY_W = START_W + BYTES_W + 1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_NO_FIT   = 2'd2;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [BYTES_W-1:0]  request_bytes;
        logic [START_W-1:0]  release_offset;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [START_W-1:0]  payload_offset;
        logic [1:0]          status;
    } rsp_t;

    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [BYTES_W-1:0]  bytes;
        logic                used;
    } entry_t;

endpackage

// ----- hw/rtl/ffha_ram.sv -----
module ffha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator with coalescing.
// The s_ channel takes one request word: func 0 allocates request_bytes of
// payload, func 1 frees the segment whose payload starts at release_offset.
// The m_ channel returns exactly one result word per request: ok, the granted
// payload offset (0 otherwise) and a status code.
// The segment table lives in one single-port-write, registered-read RAM and
// one sequencer walks it, one entry at a time.
// A request reads the table entry by entry, and also moves entries one by
// one when a split inserts an entry or a merge removes one. A bad size is
// answered in the cycle after the request is taken.
// The block holds s_ready low while a request is at work and while its
// result word waits; a stalled receiver therefore holds off the next request.
// After aresetn the table holds one free segment covering the whole heap;
// entry 0 is written in ST_INIT, the state right after reset, while s_ready
// is still low.
module first_fit_heap_allocator (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ffha_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ffha_pkg::rsp_t  m_data
);

    localparam int unsigned IW = ffha_pkg::IDX_W;
    localparam int unsigned CW = ffha_pkg::CNT_W;
    localparam int unsigned BW = ffha_pkg::BYTES_W;
    localparam int unsigned SW = ffha_pkg::START_W;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_RD, ST_CHK, ST_INS_RD, ST_INS_WR, ST_SPLIT,
        ST_PRV_RD, ST_PRV_CHK, ST_NXT_RD, ST_NXT_CHK, ST_DRP_RD, ST_DRP_WR,
        ST_OUT
    } state_t;

    state_t state_reg;
    ffha_pkg::req_t req_reg;
    ffha_pkg::rsp_t rsp_reg;
    ffha_pkg::entry_t cur_reg;
    logic [IW-1:0] idx_reg, mv_reg, drop_reg;
    logic [CW-1:0] cnt_reg;
    logic        merge2_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    ffha_pkg::entry_t wr_data, rd_data;

    ffha_ram #(.WIDTH(ffha_pkg::ENTRY_W), .DEPTH(ffha_pkg::MAX_SEGMENTS)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic [BW:0] need;
    assign need = {1'b0, req_reg.request_bytes} + (BW+1)'(ffha_pkg::HEADER_BYTES);
    logic [CW-1:0] idx_ext;
    assign idx_ext = {1'b0, idx_reg};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = rsp_reg;

    // RAM port control by state.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = cur_reg;
        rd_addr = idx_reg;
        case (state_reg)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{start: '0, bytes: BW'(ffha_pkg::HEAP_BYTES), used: 1'b0};
            end
            ST_INS_RD: rd_addr = mv_reg - 1'b1;
            ST_INS_WR: begin
                wr_en = 1'b1; wr_addr = mv_reg; wr_data = rd_data;
            end
            // The first write of a split stores the granted part; every other
            // write here stores the working entry as it stands.
            ST_SPLIT: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (mv_reg != idx_reg) begin
                    wr_data = '{start: cur_reg.start, bytes: need[BW-1:0], used: 1'b1};
                end
            end
            ST_PRV_RD: rd_addr = idx_reg - 1'b1;
            ST_NXT_RD: rd_addr = idx_reg + 1'b1;
            ST_DRP_RD: rd_addr = mv_reg + 1'b1;
            ST_DRP_WR: begin
                wr_en = 1'b1; wr_addr = mv_reg; wr_data = rd_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            cnt_reg   <= CW'(1);
        end else begin
            case (state_reg)
                ST_INIT: state_reg <= ST_IDLE;
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg <= s_data;
                        idx_reg <= '0;
                        if (s_data.func == ffha_pkg::FUNC_ALLOC &&
                            (s_data.request_bytes == '0 ||
                             s_data.request_bytes >= BW'(ffha_pkg::HEAP_BYTES))) begin
                            rsp_reg   <= '{ok: 1'b0, payload_offset: '0,
                                           status: ffha_pkg::STATUS_BAD_SIZE};
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: state_reg <= ST_CHK;
                ST_CHK: begin
                    if (req_reg.func == ffha_pkg::FUNC_ALLOC) begin
                        if (!rd_data.used && {1'b0, rd_data.bytes} > need) begin
                            rsp_reg <= '{ok: 1'b1,
                                payload_offset: rd_data.start + SW'(ffha_pkg::HEADER_BYTES),
                                status: ffha_pkg::STATUS_OK};
                            if ({1'b0, rd_data.bytes} >
                                    need + (BW+1)'(ffha_pkg::HEADER_BYTES) &&
                                cnt_reg < CW'(ffha_pkg::MAX_SEGMENTS)) begin
                                cur_reg   <= rd_data;
                                mv_reg    <= cnt_reg[IW-1:0];
                                state_reg <= ST_INS_RD;
                            end else begin
                                // Whole segment taken: just mark it used.
                                cur_reg      <= '{start: rd_data.start,
                                                  bytes: rd_data.bytes, used: 1'b1};
                                mv_reg       <= idx_reg;
                                state_reg    <= ST_SPLIT;
                            end
                        end else if (idx_ext + 1'b1 >= cnt_reg) begin
                            rsp_reg   <= '{ok: 1'b0, payload_offset: '0,
                                           status: ffha_pkg::STATUS_NO_FIT};
                            state_reg <= ST_OUT;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end else begin
                        if (rd_data.used && rd_data.start +
                                SW'(ffha_pkg::HEADER_BYTES) == req_reg.release_offset) begin
                            cur_reg      <= '{start: rd_data.start,
                                              bytes: rd_data.bytes, used: 1'b0};
                            merge2_reg   <= 1'b0;
                            rsp_reg      <= '{ok: 1'b1, payload_offset: '0,
                                              status: ffha_pkg::STATUS_OK};
                            state_reg    <= (idx_reg != '0) ? ST_PRV_RD : ST_NXT_RD;
                        end else if (idx_ext + 1'b1 >= cnt_reg) begin
                            rsp_reg   <= '{ok: 1'b0, payload_offset: '0,
                                           status: ffha_pkg::STATUS_BAD_FREE};
                            state_reg <= ST_OUT;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                // Shift entries idx+1..cnt-1 up by one, from the top down.
                ST_INS_RD: begin
                    if (mv_reg == idx_reg + 1'b1) begin
                        state_reg <= ST_SPLIT;
                    end else begin
                        state_reg <= ST_INS_WR;
                    end
                end
                ST_INS_WR: begin
                    mv_reg    <= mv_reg - 1'b1;
                    state_reg <= ST_INS_RD;
                end
                // In the split case the remainder entry is written next.
                ST_SPLIT: begin
                    if (mv_reg == idx_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        cur_reg   <= '{start: cur_reg.start + need[SW-1:0],
                                       bytes: cur_reg.bytes - need[BW-1:0], used: 1'b0};
                        idx_reg   <= idx_reg + 1'b1;
                        mv_reg    <= idx_reg + 1'b1;
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_NXT_CHK;
                    end
                end
                ST_PRV_RD: state_reg <= ST_PRV_CHK;
                ST_PRV_CHK: begin
                    if (!rd_data.used) begin
                        cur_reg   <= '{start: rd_data.start,
                                       bytes: rd_data.bytes + cur_reg.bytes, used: 1'b0};
                        drop_reg  <= idx_reg;
                        mv_reg    <= idx_reg;
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_DRP_RD;
                    end else begin
                        state_reg <= ST_NXT_RD;
                    end
                end
                ST_NXT_RD: begin
                    if (idx_ext + 1'b1 < cnt_reg) begin
                        state_reg <= ST_NXT_CHK;
                        merge2_reg <= 1'b1;
                    end else begin
                        merge2_reg <= 1'b0;
                        state_reg  <= ST_NXT_CHK;
                    end
                end
                // Hands the working entry to ST_SPLIT to be written back; for a free,
                // first folds in a free successor.
                ST_NXT_CHK: begin
                    if (req_reg.func == ffha_pkg::FUNC_FREE && merge2_reg &&
                        !rd_data.used) begin
                        cur_reg.bytes <= cur_reg.bytes + rd_data.bytes;
                        merge2_reg    <= 1'b0;
                        mv_reg        <= idx_reg + 1'b1;
                        drop_reg      <= '1;
                        state_reg     <= ST_DRP_RD;
                    end else begin
                        mv_reg    <= idx_reg;
                        merge2_reg <= 1'b0;
                        state_reg <= ST_SPLIT;
                    end
                end
                // Close the gap at mv: entries mv+1..cnt-1 move down by one.
                ST_DRP_RD: begin
                    if ({1'b0, mv_reg} + 1'b1 >= cnt_reg) begin
                        cnt_reg <= cnt_reg - 1'b1;
                        // After a predecessor merge, try the successor too.
                        state_reg <= (drop_reg != '1) ? ST_NXT_RD : ST_NXT_CHK;
                        drop_reg  <= '0;
                    end else begin
                        state_reg <= ST_DRP_WR;
                    end
                end
                ST_DRP_WR: begin
                    mv_reg    <= mv_reg + 1'b1;
                    state_reg <= ST_DRP_RD;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
